// ----- rtl/core/mi3_pkg.sv -----
// Shared types and constants for the 3x3 matrix inverse unit.
package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NLANE         = 9;
    localparam int DEN_W         = 96;   // |det| < 2^96
    localparam int QB            = 34;   // quotient bits; top bits flag overflow
    localparam int THR_W         = 31;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic               singular;
        logic               saturated;
    } inv_t;

    // travels alongside the divider data
    typedef struct packed {
        logic             singular;
        logic [NLANE-1:0] neg;
    } div_flags_t;

    // cofactor i = e[A]*e[B] - e[C]*e[D], elements row-major
    localparam logic [3:0] COF_A [NLANE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] COF_B [NLANE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] COF_C [NLANE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] COF_D [NLANE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // first-row expansion: a00*C0 + a01*C3 + a02*C6
    localparam logic [3:0] DET_COF [3] = '{4'd0, 4'd3, 4'd6};

endpackage

// ----- rtl/core/mi3_div_step.sv -----
// One restoring-division step for all nine lanes, with its own pipeline register.
module mi3_div_step
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SHIFT     = 0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic [NLANE-1:0][64+2*FRAC_BITS-1:0] up_rem,
    input  logic [NLANE-1:0][QB-1:0]          up_quo,
    input  logic [DEN_W-1:0]                  up_den,
    input  div_flags_t                        up_flags,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic [NLANE-1:0][64+2*FRAC_BITS-1:0] dn_rem,
    output logic [NLANE-1:0][QB-1:0]          dn_quo,
    output logic [DEN_W-1:0]                  dn_den,
    output div_flags_t                        dn_flags
);

    localparam int RW = 64 + 2*FRAC_BITS;
    localparam int CW = DEN_W + QB;

    logic                          valid_reg;
    logic [NLANE-1:0][RW-1:0]      rem_reg, rem_next;
    logic [NLANE-1:0][QB-1:0]      quo_reg, quo_next;
    logic [DEN_W-1:0]              den_reg;
    div_flags_t                    flags_reg;
    logic [CW-1:0]                 dsh;
    logic [CW-1:0]                 rext;

    assign up_ready = ~valid_reg | dn_ready;
    assign dsh      = CW'(up_den) << SHIFT;

    always_comb
    begin
        rext     = '0;
        rem_next = up_rem;
        quo_next = up_quo;
        for (int l = 0; l < NLANE; l++)
        begin
            rext = CW'(up_rem[l]);
            if (rext >= dsh)
            begin
                rem_next[l]        = RW'(rext - dsh);
                quo_next[l][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            den_reg   <= up_den;
            flags_reg <= up_flags;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_quo   = quo_reg;
    assign dn_den   = den_reg;
    assign dn_flags = flags_reg;

endmodule

// ----- rtl/core/matrix_inverse_3x3_unit.sv -----
// 3x3 matrix inverse by adjugate over determinant, top level.
// Takes one matrix and returns one inverse per clock when the output is not stalled;
// 7 cofactor/determinant stages, 34 one-bit restoring divider stages, output stage.
// Every stage holds its item and accepts a new one when empty or when the next stage
// moves, so a stalled output fills the pipe before mat_ready drops. The user writes
// det_threshold via cfg only while no item is in flight (not enforced); reset is 1.
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mat_valid,
    output logic             mat_ready,
    input  mat_t             mat,
    output logic             inv_valid,
    input  logic             inv_ready,
    output inv_t             inv,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    localparam int RW = 64 + 2*FRAC_BITS;
    localparam int NS = 7;

    logic [THR_W-1:0] thr_reg;

    logic [NS-1:0]    v_reg;
    logic [NS:0]      rdy;

    // stage 0: elements
    logic signed [31:0] e_reg [NLANE];
    // stage 1: raw products
    logic signed [63:0] prd_reg [2*NLANE];
    logic signed [31:0] e1_reg [3];
    // stage 2: cofactors
    logic signed [64:0] cof2_reg [NLANE];
    logic signed [31:0] e2_reg [3];
    // stage 3: split determinant products
    logic signed [64:0] pl_reg [3];
    logic signed [64:0] ph_reg [3];
    logic signed [64:0] cof3_reg [NLANE];
    // stage 4: determinant terms
    logic signed [96:0] term_reg [3];
    logic signed [64:0] cof4_reg [NLANE];
    // stage 5: determinant
    logic signed [97:0] det_reg;
    logic signed [64:0] cof5_reg [NLANE];
    // stage 6: divider operands
    logic [NLANE-1:0][RW-1:0] num_reg;
    logic [DEN_W-1:0]         absd_reg;
    div_flags_t               flg_reg;

    logic [NLANE-1:0][RW-1:0] num_next;
    logic [DEN_W-1:0]         absd_next;
    div_flags_t               flg_next;
    logic signed [97:0]       neg_det;
    logic signed [64:0]       neg_cof;

    // config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(1);
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // front pipeline handshake
    assign rdy[NS-1:0] = ~v_reg | rdy[NS:1];

    assign mat_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= mat_valid;
            for (int k = 1; k < NS; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && mat_valid)
        begin
            e_reg[0] <= mat.m00;
            e_reg[1] <= mat.m01;
            e_reg[2] <= mat.m02;
            e_reg[3] <= mat.m10;
            e_reg[4] <= mat.m11;
            e_reg[5] <= mat.m12;
            e_reg[6] <= mat.m20;
            e_reg[7] <= mat.m21;
            e_reg[8] <= mat.m22;
        end
        if (rdy[1] && v_reg[0])
        begin
            for (int i = 0; i < NLANE; i++)
            begin
                prd_reg[2*i]   <= 64'(e_reg[COF_A[i]]) * 64'(e_reg[COF_B[i]]);
                prd_reg[2*i+1] <= 64'(e_reg[COF_C[i]]) * 64'(e_reg[COF_D[i]]);
            end
            for (int j = 0; j < 3; j++)
                e1_reg[j] <= e_reg[j];
        end
        if (rdy[2] && v_reg[1])
        begin
            for (int i = 0; i < NLANE; i++)
                cof2_reg[i] <= 65'(prd_reg[2*i]) - 65'(prd_reg[2*i+1]);
            e2_reg <= e1_reg;
        end
        if (rdy[3] && v_reg[2])
        begin
            // 32 x 65 product split into two 32 x 33 halves
            for (int j = 0; j < 3; j++)
            begin
                pl_reg[j] <= 65'(e2_reg[j]) * 65'($signed({1'b0, cof2_reg[DET_COF[j]][31:0]}));
                ph_reg[j] <= 65'(e2_reg[j]) * 65'($signed(cof2_reg[DET_COF[j]][64:32]));
            end
            cof3_reg <= cof2_reg;
        end
        if (rdy[4] && v_reg[3])
        begin
            for (int j = 0; j < 3; j++)
                term_reg[j] <= (97'(ph_reg[j]) <<< 32) + 97'(pl_reg[j]);
            cof4_reg <= cof3_reg;
        end
        if (rdy[5] && v_reg[4])
        begin
            det_reg  <= 98'(term_reg[0]) + 98'(term_reg[1]) + 98'(term_reg[2]);
            cof5_reg <= cof4_reg;
        end
        if (rdy[6] && v_reg[5])
        begin
            num_reg  <= num_next;
            absd_reg <= absd_next;
            flg_reg  <= flg_next;
        end
    end

    // magnitudes, signs and the singular test
    always_comb
    begin
        neg_det   = -det_reg;
        absd_next = det_reg[97] ? neg_det[DEN_W-1:0] : det_reg[DEN_W-1:0];
        flg_next.singular = absd_next <= (DEN_W'(thr_reg) << (2*FRAC_BITS));
        neg_cof   = '0;
        num_next  = '0;
        flg_next.neg = '0;
        for (int i = 0; i < NLANE; i++)
        begin
            neg_cof = -cof5_reg[i];
            flg_next.neg[i] = cof5_reg[i][64] ^ det_reg[97];
            num_next[i] = {(cof5_reg[i][64] ? neg_cof[63:0] : cof5_reg[i][63:0]),
                           {(2*FRAC_BITS){1'b0}}};
        end
    end

    // divider chain: one quotient bit per stage, MSB first
    logic [QB:0]                     dv_valid;
    logic [QB:0]                     dv_ready;
    logic [QB:0][NLANE-1:0][RW-1:0]  dv_rem;
    logic [QB:0][NLANE-1:0][QB-1:0]  dv_quo;
    logic [QB:0][DEN_W-1:0]          dv_den;
    div_flags_t                      dv_flags [QB+1];

    assign dv_valid[0] = v_reg[NS-1];
    assign rdy[NS]     = dv_ready[0];
    assign dv_rem[0]   = num_reg;
    assign dv_quo[0]   = '0;
    assign dv_den[0]   = absd_reg;
    assign dv_flags[0] = flg_reg;

    for (genvar g = 0; g < QB; g++)
    begin : g_div
        mi3_div_step #(
            .FRAC_BITS (FRAC_BITS),
            .SHIFT     (QB-1-g)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (dv_valid[g]),
            .up_ready (dv_ready[g]),
            .up_rem   (dv_rem[g]),
            .up_quo   (dv_quo[g]),
            .up_den   (dv_den[g]),
            .up_flags (dv_flags[g]),
            .dn_valid (dv_valid[g+1]),
            .dn_ready (dv_ready[g+1]),
            .dn_rem   (dv_rem[g+1]),
            .dn_quo   (dv_quo[g+1]),
            .dn_den   (dv_den[g+1]),
            .dn_flags (dv_flags[g+1])
        );
    end

    // sign, saturation and output register
    logic                     out_v_reg;
    inv_t                     out_reg;
    inv_t                     out_next;
    logic [NLANE-1:0][31:0]   res;
    logic [NLANE-1:0]         sat;
    logic [QB-1:0]            q;

    assign dv_ready[QB] = ~out_v_reg | inv_ready;

    always_comb
    begin
        q   = '0;
        res = '0;
        sat = '0;
        for (int l = 0; l < NLANE; l++)
        begin
            q = dv_quo[QB][l];
            if (!dv_flags[QB].neg[l])
            begin
                if (q[QB-1:31] != '0)
                begin
                    sat[l] = 1'b1;
                    res[l] = 32'h7FFF_FFFF;
                end
                else
                    res[l] = q[31:0];
            end
            else
            begin
                if (q[QB-1:32] != '0 || (q[31] && q[30:0] != '0))
                begin
                    sat[l] = 1'b1;
                    res[l] = 32'h8000_0000;
                end
                else
                    res[l] = 32'(0) - q[31:0];
            end
        end
        if (dv_flags[QB].singular)
        begin
            res = '0;
            sat = '0;
        end
        out_next.r00       = res[0];
        out_next.r01       = res[1];
        out_next.r02       = res[2];
        out_next.r10       = res[3];
        out_next.r11       = res[4];
        out_next.r12       = res[5];
        out_next.r20       = res[6];
        out_next.r21       = res[7];
        out_next.r22       = res[8];
        out_next.singular  = dv_flags[QB].singular;
        out_next.saturated = |sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (dv_ready[QB])
            out_v_reg <= dv_valid[QB];
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready[QB] && dv_valid[QB])
            out_reg <= out_next;
    end

    assign inv_valid = out_v_reg;
    assign inv       = out_reg;

    // an empty output register means the whole pipe can take an item
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !inv_valid |-> mat_ready)
        else $error("input stalled with empty output");

    a_singular_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.singular |-> !inv.saturated)
        else $error("singular item flagged saturated");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.singular |-> inv.r00 == 0 && inv.r11 == 0 && inv.r22 == 0)
        else $error("singular item with nonzero result");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-1] && !rdy[NS] |=> v_reg[NS-1] && $stable(absd_reg))
        else $error("divider operands lost during stall");

endmodule

// ----- test/matrix_inverse_3x3_unit_checker.sv -----
// Checker for the 3x3 matrix inverse unit: predicts each inverse and compares.
`timescale 1ns / 100ps
module matrix_inverse_3x3_unit_checker
    import mi3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mat_valid,
    input  logic             mat_ready,
    input  mat_t             mat,
    input  logic             inv_valid,
    input  logic             inv_ready,
    input  inv_t             inv,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data,
    output int               mismatches,
    output int               pending
);

    localparam int F2 = 2 * FRAC_BITS_DEF;

    inv_t             inverse_q [$];
    logic [THR_W-1:0] threshold;

    function automatic inv_t predict_inverse(mat_t m, logic [THR_W-1:0] thr);
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic [127:0]        abs_det;
        logic [127:0]        abs_cof;
        logic [127:0]        quot;
        logic [127:0]        limit;
        logic [31:0]         lane [9];
        logic                neg;
        logic                sat;
        e[0] = m.m00; e[1] = m.m01; e[2] = m.m02;
        e[3] = m.m10; e[4] = m.m11; e[5] = m.m12;
        e[6] = m.m20; e[7] = m.m21; e[8] = m.m22;
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[2] * e[3] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[1] * e[6] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        abs_det = det[127] ? -det : det;
        limit = {97'd0, thr} << F2;
        if (abs_det <= limit)
            return {288'd0, 1'b1, 1'b0};
        sat = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            abs_cof = cof[i][127] ? -cof[i] : cof[i];
            quot = (abs_cof << F2) / abs_det;
            neg = cof[i][127] ^ det[127];
            if (!neg)
            begin
                if (quot > 128'h7FFF_FFFF)
                begin
                    sat = 1'b1;
                    lane[i] = 32'h7FFF_FFFF;
                end
                else
                    lane[i] = quot[31:0];
            end
            else if (quot > 128'h8000_0000)
            begin
                sat = 1'b1;
                lane[i] = 32'h8000_0000;
            end
            else
                lane[i] = -quot[31:0];
        end
        return {lane[0], lane[1], lane[2], lane[3], lane[4], lane[5], lane[6], lane[7],
                lane[8], 1'b0, sat};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        inv_t want;
        if (!rst_n)
        begin
            threshold  <= 31'd1;
            mismatches <= 0;
            pending    <= 0;
            inverse_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                threshold <= cfg_data;
            if (mat_valid && mat_ready)
                inverse_q.push_back(predict_inverse(mat, threshold));
            if (inv_valid && inv_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected item %h", $time, inv);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    if (want !== inv)
                    begin
                        for (int i = 0; i < 9; i++)
                            if (want[289 - 32 * i -: 32] !== inv[289 - 32 * i -: 32])
                                $display("%0t: r%0d%0d expected %h got %h", $time, i / 3,
                                         i % 3, want[289 - 32 * i -: 32],
                                         inv[289 - 32 * i -: 32]);
                        if (want.singular !== inv.singular)
                            $display("%0t: singular expected %b got %b", $time,
                                     want.singular, inv.singular);
                        if (want.saturated !== inv.saturated)
                            $display("%0t: saturated expected %b got %b", $time,
                                     want.saturated, inv.saturated);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= inverse_q.size();
        end
    end

endmodule

// ----- test/matrix_inverse_3x3_unit_tb.sv -----
// Testbench top for the 3x3 matrix inverse unit: stimulus, thresholds and verdict.
`timescale 1ns / 100ps
module matrix_inverse_3x3_unit_tb;
    import mi3_pkg::*;

    localparam int  RANDOM_ITEMS = 1030;
    localparam int  PHASES       = 6;
    localparam int  DRAIN_CYCLES = 50;
    localparam longint CYCLE_LIMIT = 1_000_000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             mat_valid = 1'b0;
    logic             mat_ready;
    mat_t             mat = '0;
    logic             inv_valid;
    logic             inv_ready = 1'b0;
    inv_t             inv;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data = '0;
    int               mismatches;
    int               pending;
    logic             quiet = 1'b0;
    int               stall_left = 0;
    longint           cycles = 0;

    matrix_inverse_3x3_unit dut (
        .clk(clk), .rst_n(rst_n),
        .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
        .inv_valid(inv_valid), .inv_ready(inv_ready), .inv(inv),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    matrix_inverse_3x3_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
        .inv_valid(inv_valid), .inv_ready(inv_ready), .inv(inv),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[matrix_inverse_3x3_unit] ERROR");
            $finish;
        end
    end

    // receiver backpressure in bursts
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            inv_ready = rst_n;
        else if (stall_left > 0)
        begin
            stall_left--;
            inv_ready = 1'b0;
        end
        else
        begin
            inv_ready = 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 14);
        end
    end

    function automatic logic [31:0] rand_elem(int kind);
        case (kind)
            0:       return $urandom;
            1:       return $urandom_range(0, 1 << 20) - (1 << 19);  // about +-8.0
            2:       return $urandom_range(0, 510) - 255;            // tiny raw values
            default: return $urandom_range(0, 1 << 17) - (1 << 16);  // about +-1.0
        endcase
    endfunction

    function automatic mat_t rand_matrix();
        logic [31:0] e [9];
        int kind;
        kind = $urandom_range(0, 5);
        for (int i = 0; i < 9; i++)
            e[i] = rand_elem(kind > 3 ? 1 : kind);
        if (kind == 4)
        begin
            // third row is a sum of the first two: singular or nearly so
            for (int j = 0; j < 3; j++)
                e[6 + j] = e[j] + e[3 + j] + $urandom_range(0, 2) - 1;
        end
        else if (kind == 5)
        begin
            for (int j = 0; j < 3; j++)
                e[4 * j] = e[4 * j] + 32'sd262144;   // diagonal shifted up by 4.0
        end
        return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    function automatic mat_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        return {a, 32'd0, 32'd0, 32'd0, b, 32'd0, 32'd0, 32'd0, c};
    endfunction

    task automatic send_matrix(mat_t x);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            mat_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        mat_valid = 1'b1;
        mat = x;
        @(posedge clk);
        while (!mat_ready) @(posedge clk);
    endtask

    // drain everything, let the pipe settle, then load a new threshold
    task automatic write_threshold(logic [THR_W-1:0] thr);
        @(negedge clk);
        mat_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = thr;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        logic [THR_W-1:0] phase_thr [PHASES];
        phase_thr = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd65536, 31'd0, 31'd1};
        phase_thr[3] = THR_W'($urandom);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset threshold of one LSB (2^-16)
        send_matrix(diag(32'd65536, 32'd65536, 32'd65536));
        send_matrix('0);
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix({9{32'h8000_0000}});
        send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_matrix(diag(32'hFFFF_FFFE, 32'd65536, 32'd65536));  // exactly -2^31, no clip
        send_matrix(diag(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000));
        send_matrix({32'd65536, 32'd131072, 32'd196608, 32'd262144, 32'd327680,
                     32'd393216, 32'd458752, 32'd524288, 32'd655360});
        send_matrix({32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_4000,
                     32'h0003_0000, 32'hFFFE_0000, 32'h0000_2000, 32'h0001_8000,
                     32'h0002_0000});
        write_threshold(31'd327680);
        send_matrix(diag(32'd65536, 32'd65536, 32'd327680));      // |D| equals limit
        write_threshold(31'd327679);
        send_matrix(diag(32'd65536, 32'd65536, 32'd327680));      // just above limit
        write_threshold(31'd0);
        send_matrix(diag(32'd1, 32'd1, 32'd1));                   // overflow both signs
        send_matrix(diag(32'hFFFF_FFFF, 32'd1, 32'd1));
        send_matrix({32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        send_matrix({9{32'h5555_5555}});
        send_matrix({9{32'hAAAA_AAAA}});

        for (int p = 0; p < PHASES; p++)
        begin
            write_threshold(phase_thr[p]);
            if (p == PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                send_matrix(rand_matrix());
        end

        @(negedge clk);
        mat_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[matrix_inverse_3x3_unit] OK");
        else
            $display("[matrix_inverse_3x3_unit] ERROR");
        $finish;
    end

endmodule
